@@ rtl/core/kvi_pkg.sv @@
// shared constants, codes and types of the keyframe vec4 interpolator
package kvi_pkg;

  localparam int MAX_KEYS_DEF       = 16;
  localparam int STEP_FRAC_BITS_DEF = 16;

  // quotient bits retired by the shared divider per cycle
  localparam int DIV_RADIX_BITS = 4;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int VAL_W    = 32;
  localparam int NUM_COMP = 4;

  localparam logic signed [VAL_W-1:0] VAL_ONE = 32'sd65536;

  localparam logic [CMD_W-1:0] CMD_SET_KEY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROGRESS = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_VALUE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_STORED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_STARTED = 2'd3;

  typedef enum logic [4:0] {
    ST_INIT0,
    ST_INIT1,
    ST_IDLE,
    ST_DECODE,
    ST_SK_RD,
    ST_SK_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_SK_WR,
    ST_SR_RD,
    ST_SR_CMP,
    ST_LD_A,
    ST_LD_B,
    ST_LD_C,
    ST_MUL,
    ST_DIV_PREP,
    ST_DIV,
    ST_ACC
  } state_t;

endpackage

@@ rtl/core/kvi_ram.sv @@
// generic simple dual port ram with registered read
module kvi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/keyframe_vec4_interpolator.sv @@
// keyframe vec4 interpolator top level: key table, segment walk and shared lerp unit
//
// command channel: an item (in_cmd plus its fields) is taken at a rising edge with
// start high and busy low. set key (in_cmd 0) replaces or inserts a key in the sorted
// table; start (in_cmd 1) selects the first segment; progress (in_cmd 2) moves the
// segment forward and gives the interpolated vec4. in_cmd 3 is taken and answers nothing.
// result channel: out_valid is high for exactly one cycle with out_status and out_x..w;
// the receiver cannot stall it, so the word must be captured in that cycle.
// every command passes the decode state, then does its own work. set key drops a
// step above 1.0 or a new key for a full table; else it scans keys in turn and
// replaces an equal key, or moves each later key up, top first, and writes the new
// key. start loads the first segment. progress past the segment end searches later
// keys and loads a segment; then the four components run one at a time through the
// shared 4-bit-per-cycle divider. the key table sits in a single ram port pair, one
// entry per cycle, so keys are scanned and shifted one at a time. one command at a
// time: busy stays high until the word is out, or for in_cmd 3 until decode ends.
// reset: rst_n is synchronous; afterwards states INIT0 and INIT1 write the two
// default keys (step 0 and 1.0, all components 1.0) while busy is high.
module keyframe_vec4_interpolator #(
  parameter int MAX_KEYS       = kvi_pkg::MAX_KEYS_DEF,
  parameter int STEP_FRAC_BITS = kvi_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [kvi_pkg::CMD_W-1:0]     in_cmd,
  input  logic [STEP_FRAC_BITS:0]       in_key_step,
  input  logic [STEP_FRAC_BITS:0]       in_progress,
  input  logic signed [kvi_pkg::VAL_W-1:0] in_x,
  input  logic signed [kvi_pkg::VAL_W-1:0] in_y,
  input  logic signed [kvi_pkg::VAL_W-1:0] in_z,
  input  logic signed [kvi_pkg::VAL_W-1:0] in_w,
  output logic                          out_valid,
  output logic [kvi_pkg::STATUS_W-1:0]  out_status,
  output logic signed [kvi_pkg::VAL_W-1:0] out_x,
  output logic signed [kvi_pkg::VAL_W-1:0] out_y,
  output logic signed [kvi_pkg::VAL_W-1:0] out_z,
  output logic signed [kvi_pkg::VAL_W-1:0] out_w
);

  import kvi_pkg::*;

  // step width, table index and count widths
  localparam int SW    = STEP_FRAC_BITS + 1;
  localparam int IW    = $clog2(MAX_KEYS);
  localparam int CW    = $clog2(MAX_KEYS + 1);
  localparam int EW    = SW + NUM_COMP * VAL_W;
  // lerp datapath widths: t is signed, product of 33-bit difference and t
  localparam int TW    = SW + 1;
  localparam int PW    = VAL_W + 1 + TW;
  localparam int NSTEP = (PW + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int NW    = NSTEP * DIV_RADIX_BITS;
  localparam int RW    = NW + 2;
  localparam int DCW   = $clog2(NSTEP + 1);

  localparam logic [SW-1:0] STEP_ONE = SW'(1) << STEP_FRAC_BITS;
  localparam logic [CW-1:0] KEYS_MAX = CW'(MAX_KEYS);

  state_t state_r, state_nxt;

  // captured command word
  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [SW-1:0]           step_r, step_nxt;
  logic [SW-1:0]           prog_r, prog_nxt;
  logic signed [VAL_W-1:0] val_r [NUM_COMP];
  logic signed [VAL_W-1:0] val_nxt [NUM_COMP];

  // table bookkeeping and current segment
  logic [CW-1:0]           key_count_r, key_count_nxt;
  logic [IW-1:0]           seg_end_idx_r, seg_end_idx_nxt;
  logic [SW-1:0]           seg_step0_r, seg_step0_nxt;
  logic [SW-1:0]           seg_step1_r, seg_step1_nxt;
  logic signed [VAL_W-1:0] seg_a_r [NUM_COMP];
  logic signed [VAL_W-1:0] seg_a_nxt [NUM_COMP];
  logic signed [VAL_W-1:0] seg_b_r [NUM_COMP];
  logic signed [VAL_W-1:0] seg_b_nxt [NUM_COMP];

  // scan / search index and shift pointer
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           ptr_r, ptr_nxt;

  // shared lerp unit
  logic [1:0]              comp_r, comp_nxt;
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic                    neg_r, neg_nxt;
  logic [NW-1:0]           num_r, num_nxt;
  logic [SW-1:0]           rem_r, rem_nxt;
  logic [DCW-1:0]          cnt_r, cnt_nxt;
  logic signed [VAL_W-1:0] res_r [NUM_COMP];
  logic signed [VAL_W-1:0] res_nxt [NUM_COMP];

  // result word
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_val_r [NUM_COMP];
  logic signed [VAL_W-1:0] out_val_nxt [NUM_COMP];

  // table ram
  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [EW-1:0]           ram_rdata;
  logic [SW-1:0]           rd_step;
  logic signed [VAL_W-1:0] rd_val [NUM_COMP];
  logic [EW-1:0]           new_entry;

  // datapath helpers
  logic [SW-1:0]           den;
  logic                    den_zero;
  logic signed [TW-1:0]    tdiff;
  logic signed [VAL_W:0]   dif;
  logic signed [PW-1:0]    prod_full;
  logic [PW-1:0]           mag;
  logic [SW-1:0]           div_rem;
  logic [NW-1:0]           div_num;
  logic [SW-1:0]           rem_sh;
  logic [RW-1:0]           acc_sum;
  logic signed [VAL_W-1:0] acc_sat;
  logic                    accept;

  kvi_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_KEYS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry layout: step above x, y, z, w
  assign rd_step = ram_rdata[EW-1 -: SW];
  always_comb begin
    for (int k = 0; k < NUM_COMP; k++) begin
      rd_val[k] = ram_rdata[(NUM_COMP-1-k)*VAL_W +: VAL_W];
    end
  end
  assign new_entry = {step_r, val_r[0], val_r[1], val_r[2], val_r[3]};

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // segment geometry; the table keeps steps strictly rising, so den is positive
  assign den      = seg_step1_r - seg_step0_r;
  assign den_zero = (seg_step1_r <= seg_step0_r);
  assign tdiff    = $signed({1'b0, prog_r}) - $signed({1'b0, seg_step0_r});
  assign dif      = $signed({seg_b_r[comp_r][VAL_W-1], seg_b_r[comp_r]})
                  - $signed({seg_a_r[comp_r][VAL_W-1], seg_a_r[comp_r]});
  assign prod_full = dif * tdiff;
  assign mag       = prod_r[PW-1] ? (~prod_r + PW'(1)) : prod_r;

  // restoring divider, DIV_RADIX_BITS quotient bits per cycle
  // quotient bits shift into num from the bottom as numerator bits leave the top
  always_comb begin
    div_rem = rem_r;
    div_num = num_r;
    rem_sh  = '0;
    for (int b = 0; b < DIV_RADIX_BITS; b++) begin
      rem_sh  = {div_rem[SW-2:0], div_num[NW-1]};
      div_num = {div_num[NW-2:0], 1'b0};
      if (rem_sh >= den) begin
        div_rem    = rem_sh - den;
        div_num[0] = 1'b1;
      end else begin
        div_rem = rem_sh;
      end
    end
  end

  // start value plus or minus the rounded quotient, then saturate to 32 bits
  assign acc_sum = neg_r ? (RW'(seg_a_r[comp_r]) - {2'b00, num_r})
                         : (RW'(seg_a_r[comp_r]) + {2'b00, num_r});
  always_comb begin
    if ((&acc_sum[RW-1:VAL_W-1]) || !(|acc_sum[RW-1:VAL_W-1])) begin
      acc_sat = acc_sum[VAL_W-1:0];
    end else if (acc_sum[RW-1]) begin
      acc_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT0;
      key_count_r   <= CW'(2);
      seg_end_idx_r <= IW'(1);
      seg_step0_r   <= '0;
      seg_step1_r   <= STEP_ONE;
      for (int k = 0; k < NUM_COMP; k++) begin
        seg_a_r[k] <= VAL_ONE;
        seg_b_r[k] <= VAL_ONE;
      end
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      key_count_r   <= key_count_nxt;
      seg_end_idx_r <= seg_end_idx_nxt;
      seg_step0_r   <= seg_step0_nxt;
      seg_step1_r   <= seg_step1_nxt;
      seg_a_r       <= seg_a_nxt;
      seg_b_r       <= seg_b_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    step_r       <= step_nxt;
    prog_r       <= prog_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    comp_r       <= comp_nxt;
    prod_r       <= prod_nxt;
    neg_r        <= neg_nxt;
    num_r        <= num_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    step_nxt        = step_r;
    prog_nxt        = prog_r;
    val_nxt         = val_r;
    key_count_nxt   = key_count_r;
    seg_end_idx_nxt = seg_end_idx_r;
    seg_step0_nxt   = seg_step0_r;
    seg_step1_nxt   = seg_step1_r;
    seg_a_nxt       = seg_a_r;
    seg_b_nxt       = seg_b_r;
    idx_nxt         = idx_r;
    ptr_nxt         = ptr_r;
    comp_nxt        = comp_r;
    prod_nxt        = prod_r;
    neg_nxt         = neg_r;
    num_nxt         = num_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;
    res_nxt         = res_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_val_nxt     = out_val_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r[IW-1:0];
    ram_wdata       = new_entry;
    ram_raddr       = idx_r[IW-1:0];

    unique case (state_r)
      // write the two default keys
      ST_INIT0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {{SW{1'b0}}, VAL_ONE, VAL_ONE, VAL_ONE, VAL_ONE};
        state_nxt = ST_INIT1;
      end
      ST_INIT1: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(1);
        ram_wdata = {STEP_ONE, VAL_ONE, VAL_ONE, VAL_ONE, VAL_ONE};
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_cmd;
          step_nxt   = in_key_step;
          prog_nxt   = in_progress;
          val_nxt[0] = in_x;
          val_nxt[1] = in_y;
          val_nxt[2] = in_z;
          val_nxt[3] = in_w;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (cmd_r)
          CMD_SET_KEY: begin
            if (step_r > STEP_ONE) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_DROPPED;
              out_val_nxt    = '{default: '0};
              state_nxt      = ST_IDLE;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_SK_RD;
            end
          end
          CMD_START: begin
            idx_nxt   = CW'(1);
            state_nxt = ST_LD_A;
          end
          CMD_PROGRESS: begin
            comp_nxt = '0;
            if (prog_r > seg_step1_r) begin
              idx_nxt   = CW'(seg_end_idx_r) + CW'(1);
              state_nxt = ST_SR_RD;
            end else begin
              state_nxt = ST_MUL;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      // set key: scan for an equal or larger step
      ST_SK_RD: begin
        if (idx_r >= key_count_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DROPPED;
          out_val_nxt    = '{default: '0};
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_SK_CMP;
        end
      end
      ST_SK_CMP: begin
        if (rd_step == step_r) begin
          ram_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_STORED;
          out_val_nxt    = '{default: '0};
          state_nxt      = ST_IDLE;
        end else if (rd_step > step_r) begin
          if (key_count_r == KEYS_MAX) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_DROPPED;
            out_val_nxt    = '{default: '0};
            state_nxt      = ST_IDLE;
          end else begin
            ptr_nxt   = key_count_r;
            state_nxt = ST_SH_RD;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_SK_RD;
        end
      end
      // open a hole at idx by moving entries up, top first
      ST_SH_RD: begin
        ram_raddr = ptr_r[IW-1:0] - IW'(1);
        state_nxt = ST_SH_WR;
      end
      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r[IW-1:0];
        ram_wdata = ram_rdata;
        if ((ptr_r - CW'(1)) == idx_r) begin
          state_nxt = ST_SK_WR;
        end else begin
          ptr_nxt   = ptr_r - CW'(1);
          state_nxt = ST_SH_RD;
        end
      end
      ST_SK_WR: begin
        ram_we         = 1'b1;
        key_count_nxt  = key_count_r + CW'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_STORED;
        out_val_nxt    = '{default: '0};
        state_nxt      = ST_IDLE;
      end
      // progress: look for the first later key at or past progress
      ST_SR_RD: begin
        if (idx_r >= key_count_r) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SR_CMP;
        end
      end
      ST_SR_CMP: begin
        if (rd_step >= prog_r) begin
          state_nxt = ST_LD_A;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_SR_RD;
        end
      end
      // segment load: entries idx-1 and idx
      ST_LD_A: begin
        ram_raddr = idx_r[IW-1:0] - IW'(1);
        state_nxt = ST_LD_B;
      end
      ST_LD_B: begin
        seg_step0_nxt = rd_step;
        seg_a_nxt     = rd_val;
        state_nxt     = ST_LD_C;
      end
      ST_LD_C: begin
        seg_step1_nxt   = rd_step;
        seg_b_nxt       = rd_val;
        seg_end_idx_nxt = idx_r[IW-1:0];
        if (cmd_r == CMD_START) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_STARTED;
          out_val_nxt    = '{default: '0};
          state_nxt      = ST_IDLE;
        end else begin
          comp_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      // lerp of one component through the shared multiplier and divider
      ST_MUL: begin
        if (den_zero) begin
          res_nxt[comp_r] = seg_a_r[comp_r];
          if (comp_r == 2'(NUM_COMP - 1)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_VALUE;
            out_val_nxt    = res_nxt;
            state_nxt      = ST_IDLE;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end else begin
          prod_nxt  = prod_full;
          state_nxt = ST_DIV_PREP;
        end
      end
      ST_DIV_PREP: begin
        neg_nxt   = prod_r[PW-1];
        num_nxt   = NW'(mag) + NW'(den >> 1);
        rem_nxt   = '0;
        cnt_nxt   = DCW'(NSTEP);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        num_nxt = div_num;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r - DCW'(1);
        if (cnt_r == DCW'(1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        res_nxt[comp_r] = acc_sat;
        if (comp_r == 2'(NUM_COMP - 1)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_VALUE;
          out_val_nxt    = res_nxt;
          state_nxt      = ST_IDLE;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_x      = out_val_r[0];
  assign out_y      = out_val_r[1];
  assign out_z      = out_val_r[2];
  assign out_w      = out_val_r[3];

endmodule

@@ rtl/core/kvi_checker.sv @@
// port level checker for the keyframe vec4 interpolator and its bind
module kvi_port_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic [kvi_pkg::STATUS_W-1:0]     out_status,
  input logic signed [kvi_pkg::VAL_W-1:0] out_x,
  input logic signed [kvi_pkg::VAL_W-1:0] out_y,
  input logic signed [kvi_pkg::VAL_W-1:0] out_z,
  input logic signed [kvi_pkg::VAL_W-1:0] out_w
);

  import kvi_pkg::*;

  // an accepted word makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("no busy after accept");

  // a result word appears only once the block has finished its command
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word while busy");

  // result words never come two in a row
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back to back result words");

  // vector fields are zero unless a value is given
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_VALUE) |->
      (out_x == '0) && (out_y == '0) && (out_z == '0) && (out_w == '0))
    else $error("nonzero vector on status word");

endmodule

bind keyframe_vec4_interpolator kvi_port_checker u_kvi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_x      (out_x),
  .out_y      (out_y),
  .out_z      (out_z),
  .out_w      (out_w)
);
